// ===== design/spq_pkg.sv =====
// Shared types, sizes and helpers for the strict-priority FIFO queue.
// Depends on nothing; every other design file refers to it by scoped names.
package spq_pkg;

   localparam int LEVEL_COUNT = 5;
   localparam int LEVEL_DEPTH = 16;

   localparam int ID_W  = 16;
   localparam int CX_W  = 3;
   localparam int URG_W = 3;

   localparam int LVL_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int PTR_W       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
   localparam int STORE_DEPTH = LEVEL_COUNT * LEVEL_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_SERVE = 1'b1;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_DROPPED = 2'd1,
      ST_SERVED  = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   order_id;
      logic [CX_W-1:0]   complexity;
      logic [URG_W-1:0]  urgency;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   served_id;
      logic [CX_W-1:0]   served_complexity;
      logic [URG_W-1:0]  served_urgency;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   order_id;
      logic [CX_W-1:0]   complexity;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } store_req_type;

   typedef struct packed {
      logic    start;
      req_type item;
      logic    rsp_free;
   } seq_cmd_type;

   typedef struct packed {
      logic    idle;
      logic    done;
      rsp_type result;
   } seq_stat_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(LEVEL_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] ptr);
      return ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr);
   endfunction

endpackage

// ===== design/spq_store.sv =====
// Entry store: one single-port memory holding every level's slots.
// Depends on spq_pkg for sizes and the entry and request types.
module spq_store (
   input  logic                  clock,
   input  spq_pkg::store_req_type store_req,
   output spq_pkg::entry_type    rd_data
);

   spq_pkg::entry_type mem [spq_pkg::STORE_DEPTH];
   spq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.addr] <= store_req.data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/spq_seq.sv =====
// Sequencer: per-level pointers and counts, one shared level check, scan.
// Depends on spq_pkg; drives the entry store through one request struct.
module spq_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::seq_cmd_type   cmd,
   output spq_pkg::seq_stat_type  stat,
   output spq_pkg::store_req_type store_req,
   input  spq_pkg::entry_type     rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   spq_pkg::req_type            item_ff, item_in;
   logic [spq_pkg::LVL_W-1:0]   sel_ff, sel_in;
   spq_pkg::status_type         status_ff, status_in;
   logic [spq_pkg::PTR_W-1:0]   head_ff [spq_pkg::LEVEL_COUNT];
   logic [spq_pkg::PTR_W-1:0]   head_in [spq_pkg::LEVEL_COUNT];
   logic [spq_pkg::PTR_W-1:0]   tail_ff [spq_pkg::LEVEL_COUNT];
   logic [spq_pkg::PTR_W-1:0]   tail_in [spq_pkg::LEVEL_COUNT];
   logic [spq_pkg::CNT_W-1:0]   count_ff [spq_pkg::LEVEL_COUNT];
   logic [spq_pkg::CNT_W-1:0]   count_in [spq_pkg::LEVEL_COUNT];

   logic [spq_pkg::CNT_W-1:0]   sel_count;
   logic                        sel_empty;
   logic                        sel_full;
   logic                        new_urg_ok;
   logic                        item_urg_ok;

   // shared level check: one count read, compared against empty and full
   assign sel_count = count_ff[sel_ff];
   assign sel_empty = (sel_count == '0);
   assign sel_full  = (sel_count == spq_pkg::CNT_W'(spq_pkg::LEVEL_DEPTH));

   assign new_urg_ok  = (cmd.item.urgency != '0) &&
                        (int'(cmd.item.urgency) <= spq_pkg::LEVEL_COUNT);
   assign item_urg_ok = (item_ff.urgency != '0) &&
                        (int'(item_ff.urgency) <= spq_pkg::LEVEL_COUNT);

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      sel_in    = sel_ff;
      status_in = status_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;

      store_req.wr_en           = 1'b0;
      store_req.rd_en           = 1'b0;
      store_req.addr            = spq_pkg::store_addr(sel_ff, head_ff[sel_ff]);
      store_req.data.order_id   = item_ff.order_id;
      store_req.data.complexity = item_ff.complexity;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               item_in = cmd.item;
               if (cmd.item.kind == spq_pkg::KIND_ADD) begin
                  state_in = S_ADD;
                  sel_in   = new_urg_ok ?
                             spq_pkg::LVL_W'(cmd.item.urgency - spq_pkg::URG_W'(1)) : '0;
               end else begin
                  state_in = S_SCAN;
                  sel_in   = spq_pkg::LVL_W'(spq_pkg::LEVEL_COUNT - 1);
               end
            end
         end
         S_ADD: begin
            if (!item_urg_ok || sel_full) begin
               status_in = spq_pkg::ST_DROPPED;
            end else begin
               store_req.wr_en  = 1'b1;
               store_req.addr   = spq_pkg::store_addr(sel_ff, tail_ff[sel_ff]);
               tail_in[sel_ff]  = spq_pkg::next_ptr(tail_ff[sel_ff]);
               count_in[sel_ff] = sel_count + spq_pkg::CNT_W'(1);
               status_in        = spq_pkg::ST_ADDED;
            end
            state_in = S_FINISH;
         end
         S_SCAN: begin
            if (!sel_empty) begin
               // read the head; data is registered by the next cycle
               store_req.rd_en  = 1'b1;
               head_in[sel_ff]  = spq_pkg::next_ptr(head_ff[sel_ff]);
               count_in[sel_ff] = sel_count - spq_pkg::CNT_W'(1);
               status_in        = spq_pkg::ST_SERVED;
               state_in         = S_FINISH;
            end else if (sel_ff == '0) begin
               status_in = spq_pkg::ST_EMPTY;
               state_in  = S_FINISH;
            end else begin
               sel_in = sel_ff - spq_pkg::LVL_W'(1);
            end
         end
         S_FINISH: begin
            if (cmd.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < spq_pkg::LEVEL_COUNT; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      item_ff   <= item_in;
      sel_ff    <= sel_in;
      status_ff <= status_in;
   end

   always_comb begin
      stat.idle          = (state_ff == S_IDLE);
      stat.done          = (state_ff == S_FINISH);
      stat.result.status = status_ff;
      if (status_ff == spq_pkg::ST_SERVED) begin
         stat.result.served_id         = rd_data.order_id;
         stat.result.served_complexity = rd_data.complexity;
         stat.result.served_urgency    = spq_pkg::URG_W'(sel_ff) + spq_pkg::URG_W'(1);
      end else begin
         stat.result.served_id         = '0;
         stat.result.served_complexity = '0;
         stat.result.served_urgency    = '0;
      end
   end

endmodule

// ===== design/strict_priority_fifo_queue.sv =====
// Top level of the strict-priority FIFO queue: handshakes and result register.
// Depends on spq_pkg, spq_seq and spq_store.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_ready  spq_pkg::req_type (add or serve)
//   rsp      out        rsp_valid / rsp_ready  spq_pkg::rsp_type (one per req)
//
// An add passes through capture, level check and store write, and finish.
// A serve: the shared level check walks the levels from the most urgent down,
// one per cycle, then the head is read from the single store port. Reset
// (synchronous, active high) empties every level at once; the store itself
// is never cleared. The result register frees the engine while an earlier
// word waits; only a second finished word stalls behind it.
module strict_priority_fifo_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::seq_cmd_type   cmd;
   spq_pkg::seq_stat_type  stat;
   spq_pkg::store_req_type store_req;
   spq_pkg::entry_type     rd_data;

   logic             rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_type rsp_data_ff;
   logic             rsp_load;

   // take a new word only when the sequencer has nothing in hand
   assign req_ready    = stat.idle;
   assign cmd.start    = req_valid && req_ready;
   assign cmd.item     = req_data;
   // the result slot is free if empty or being drained this cycle
   assign cmd.rsp_free = !rsp_valid_ff || rsp_ready;

   spq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   spq_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   assign rsp_load = stat.done && cmd.rsp_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result word until it is taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= stat.result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks for the strict-priority FIFO queue, bound to the top level.
// Depends on spq_pkg for the word types and status codes.
module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spq_pkg::rsp_type rsp_data
);

   // the engine works on one word at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word was in hand");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

   // a served word names a real level
   a_served_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spq_pkg::ST_SERVED) |->
      (rsp_data.served_urgency != '0 &&
       int'(rsp_data.served_urgency) <= spq_pkg::LEVEL_COUNT))
      else $error("served level out of range");

   // every other status carries zero entry fields
   a_unserved_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != spq_pkg::ST_SERVED) |->
      (rsp_data.served_id == '0 && rsp_data.served_complexity == '0 &&
       rsp_data.served_urgency == '0))
      else $error("entry fields set on a non-served result");

   // a new result appears only while the engine was busy finishing
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work in hand");

endmodule

bind strict_priority_fifo_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
